@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Every use samples on clk and is held
// off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgl: next-cycle check failed");

`endif

@@ design/sgl_pkg.sv @@
// ----------------------------------------------------------------------------
// sgl_pkg
// Types and constants shared by the scatter/gather list builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgl_pkg;

  // Fixed field widths and limits.
  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 32;
  localparam int CHUNK_W     = 13;
  localparam int PAGE_BYTES  = 4096;
  localparam int CFG_ADDR_W  = 3;

  // Actions.
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // Register map: register index and reset value.
  localparam logic       REG_MAX_SEGS   = 1'b0;
  localparam logic [6:0] MAX_SEGS_RESET = 7'd64;

  // One input request.
  typedef struct packed {
    logic [1:0]         action;
    logic [ADDR_W-1:0]  chunk_addr;
    logic [CHUNK_W-1:0] chunk_len;
    logic               request_last;
    logic [5:0]         entry_index;
  } sgl_in_t;

  // One result.
  typedef struct packed {
    logic [1:0]        status;
    logic [6:0]        segment_count;
    logic [ADDR_W-1:0] read_addr;
    logic [LEN_W-1:0]  read_len;
    logic              merged;
  } sgl_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } sgl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic rd_issue;
    logic rd_finish;
  } sgl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_ok;
  } sgl_sts_t;

endpackage

`default_nettype wire

@@ design/sgl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgl_ctrl
// Controller: sequences capture, execution and table reads of one request,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sgl_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  sgl_pkg::sgl_sts_t sts,
  output sgl_pkg::sgl_cmd_t cmd
);
  import sgl_pkg::*;

  sgl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new value when it is empty or draining.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.read_ok) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_READ;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.rd_finish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A loaded result stays valid until it is taken.
    if (cmd.exec || cmd.rd_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

@@ design/sgl_datapath.sv @@
// ----------------------------------------------------------------------------
// sgl_datapath
// Datapath: request hold register, segment table memory, cached last
// segment, request rollback state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgl_datapath #(
  parameter int MAX_SEGS = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  sgl_pkg::sgl_cmd_t cmd,
  output sgl_pkg::sgl_sts_t sts,
  input  sgl_pkg::sgl_in_t  in_data,
  input  wire [6:0]         max_segments,
  output sgl_pkg::sgl_out_t out_data
);
  import sgl_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGS + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;

  // Segment table.
  logic [ADDR_W-1:0] seg_addr_mem [MAX_SEGS];
  logic [LEN_W-1:0]  seg_len_mem  [MAX_SEGS];

  sgl_in_t           hold_r;
  sgl_out_t          out_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [LEN_W-1:0]  rd_len_r;

  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     saved_cnt_r, saved_cnt_nxt;
  logic [LEN_W-1:0]  saved_len_r, saved_len_nxt;
  logic [ADDR_W-1:0] saved_addr_r, saved_addr_nxt;
  logic [ADDR_W-1:0] last_addr_r, last_addr_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic              in_req_r, in_req_nxt;
  logic              failed_r, failed_nxt;

  logic [CW-1:0]     lim;
  logic [CW-1:0]     idx_cw;
  logic [CW-1:0]     used_m1;
  logic [CW-1:0]     sv_cnt;
  logic [CW-1:0]     sv_cnt_m1;
  logic [LEN_W-1:0]  sv_len;
  logic [ADDR_W-1:0] sv_addr;
  logic [ADDR_W-1:0] end_addr;
  logic [LEN_W:0]    len_sum;
  logic              len_bad;
  logic              can_merge;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  wr_len;
  logic [1:0]        res_status;
  logic              res_merged;

  // Limit in force, read index and merge test against the cached last segment.
  assign lim      = (CW'(max_segments) < CW'(MAX_SEGS)) ? CW'(max_segments) : CW'(MAX_SEGS);
  assign idx_cw   = CW'(hold_r.entry_index);
  assign used_m1  = used_r - CW'(1);
  assign end_addr = last_addr_r + ADDR_W'(last_len_r);
  assign len_sum  = {1'b0, last_len_r} + (LEN_W + 1)'(hold_r.chunk_len);
  assign len_bad  = LEN_W'(hold_r.chunk_len) > LEN_W'(PAGE_BYTES);
  assign can_merge = (used_r != '0) && (end_addr == hold_r.chunk_addr) && !len_sum[LEN_W];

  // Rollback point: the stored one, or the present state for an opening chunk.
  assign sv_cnt    = in_req_r ? saved_cnt_r  : used_r;
  assign sv_cnt_m1 = sv_cnt - CW'(1);
  assign sv_addr   = in_req_r ? saved_addr_r : last_addr_r;
  assign sv_len    = in_req_r ? saved_len_r  : ((used_r != '0) ? last_len_r : '0);

  assign sts.read_ok = (hold_r.action == ACT_READ) && (idx_cw < used_r);
  assign out_data    = out_r;

  // Next state of the list for the held request.
  always_comb begin
    used_nxt       = used_r;
    saved_cnt_nxt  = saved_cnt_r;
    saved_len_nxt  = saved_len_r;
    saved_addr_nxt = saved_addr_r;
    last_addr_nxt  = last_addr_r;
    last_len_nxt   = last_len_r;
    in_req_nxt     = in_req_r;
    failed_nxt     = failed_r;
    wr_en          = 1'b0;
    wr_idx         = used_r[IDX_W-1:0];
    wr_addr        = hold_r.chunk_addr;
    wr_len         = LEN_W'(hold_r.chunk_len);
    res_status     = STAT_OK;
    res_merged     = 1'b0;
    case (hold_r.action)
      ACT_APPEND: begin
        if ((lim == '0) || len_bad) begin
          res_status = STAT_INVALID;
        end else if (failed_r) begin
          res_status = STAT_IGNORED;
        end else begin
          // The first chunk of a request records the rollback point.
          if (!in_req_r) begin
            in_req_nxt     = 1'b1;
            saved_cnt_nxt  = sv_cnt;
            saved_len_nxt  = sv_len;
            saved_addr_nxt = sv_addr;
          end
          if (hold_r.chunk_len != '0) begin
            if (can_merge) begin
              // Extend the last segment.
              wr_en        = 1'b1;
              wr_idx       = used_m1[IDX_W-1:0];
              wr_addr      = last_addr_r;
              wr_len       = len_sum[LEN_W-1:0];
              last_len_nxt = len_sum[LEN_W-1:0];
              res_merged   = 1'b1;
            end else if (used_r < lim) begin
              // Open a new segment.
              wr_en         = 1'b1;
              used_nxt      = used_r + CW'(1);
              last_addr_nxt = hold_r.chunk_addr;
              last_len_nxt  = LEN_W'(hold_r.chunk_len);
            end else begin
              // Table full: restore the rollback point.
              used_nxt      = sv_cnt;
              last_addr_nxt = sv_addr;
              last_len_nxt  = sv_len;
              failed_nxt    = 1'b1;
              res_status    = STAT_FULL;
              if (sv_cnt != '0) begin
                wr_en   = 1'b1;
                wr_idx  = sv_cnt_m1[IDX_W-1:0];
                wr_addr = sv_addr;
                wr_len  = sv_len;
              end
            end
          end
        end
        // The final chunk closes the request whatever its status.
        if (hold_r.request_last) begin
          in_req_nxt = 1'b0;
          failed_nxt = 1'b0;
        end
      end
      ACT_READ: begin
        res_status = STAT_INVALID;
      end
      ACT_CLEAR: begin
        used_nxt      = '0;
        saved_cnt_nxt = '0;
        saved_len_nxt = '0;
        in_req_nxt    = 1'b0;
        failed_nxt    = 1'b0;
      end
      default: begin
        res_status = STAT_INVALID;
      end
    endcase
  end

  // Control state of the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      saved_cnt_r <= '0;
      saved_len_r <= '0;
      in_req_r    <= 1'b0;
      failed_r    <= 1'b0;
    end else if (cmd.exec) begin
      used_r      <= used_nxt;
      saved_cnt_r <= saved_cnt_nxt;
      saved_len_r <= saved_len_nxt;
      in_req_r    <= in_req_nxt;
      failed_r    <= failed_nxt;
    end
  end

  // Cached last segment and saved start address.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      saved_addr_r <= saved_addr_nxt;
      last_addr_r  <= last_addr_nxt;
      last_len_r   <= last_len_nxt;
    end
  end

  // Request hold register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hold_r <= in_data;
    end
  end

  // Segment table write port.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      seg_addr_mem[wr_idx] <= wr_addr;
      seg_len_mem[wr_idx]  <= wr_len;
    end
  end

  // Segment table read port with registered data.
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_addr_r <= seg_addr_mem[idx_cw[IDX_W-1:0]];
      rd_len_r  <= seg_len_mem[idx_cw[IDX_W-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r.status        <= res_status;
      out_r.segment_count <= used_nxt[6:0];
      out_r.read_addr     <= '0;
      out_r.read_len      <= '0;
      out_r.merged        <= res_merged;
    end else if (cmd.rd_finish) begin
      out_r.status        <= STAT_OK;
      out_r.segment_count <= used_r[6:0];
      out_r.read_addr     <= rd_addr_r;
      out_r.read_len      <= rd_len_r;
      out_r.merged        <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/scatter_gather_list_builder.sv @@
// ----------------------------------------------------------------------------
// scatter_gather_list_builder
// Builds a DMA scatter/gather segment table from physical chunks, with
// merging of contiguous chunks and rollback of requests that overflow.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ channel (valid/ready) as one sgl_in_t each:
// append a chunk, read a segment by index, or clear the list. Every request
// produces exactly one sgl_out_t result on the out_ channel (valid/ready).
// The segment limit is set through the APB-style cfg_ port (register 0,
// max_segments); the user must write it only while the block is idle.
// The block itself does not enforce this. A request is captured into the
// hold register when accepted and executed from it once the result register
// is free; an append, clear or rejected read then loads the result and
// raises out_valid. A valid read first issues the registered table read and
// then loads the result. A new request is taken only after the last executes.
// When the receiver stalls, the result is held in the output register; one
// more request is accepted and then held until the result slot frees up.
// Reset empties the list, ends any request and sets max_segments to 64.
// Table contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scatter_gather_list_builder #(
  parameter int MAX_SEGS = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  sgl_pkg::sgl_in_t                   in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output sgl_pkg::sgl_out_t                  out_data,
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [sgl_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import sgl_pkg::*;

  sgl_cmd_t   cmd;
  sgl_sts_t   sts;
  logic [6:0] max_seg_r;
  logic       cfg_hit;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_MAX_SEGS);
  assign cfg_prdata = cfg_hit ? {25'd0, max_seg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_seg_r <= MAX_SEGS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      max_seg_r <= cfg_pwdata[6:0];
    end
  end

  // Controller.
  sgl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  sgl_datapath #(
    .MAX_SEGS (MAX_SEGS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .max_segments (max_seg_r),
    .out_data     (out_data)
  );

  // Checks.
  `SGL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SGL_ASSERT_IMP(a_merge_is_ok, out_valid && out_data.merged, out_data.status == STAT_OK && out_data.read_len == '0)
  `SGL_ASSERT_IMP(a_fail_no_data, out_valid && out_data.status != STAT_OK, out_data.read_addr == '0 && out_data.read_len == '0)

endmodule

`default_nettype wire
